// ===== rtl/iawc_pkg.sv =====
// Shared types and constants for the integer ALU with width cast.
package iawc_pkg;

	localparam logic [4:0] OP_POW = 5'd0;
	localparam logic [4:0] OP_ADD = 5'd1;
	localparam logic [4:0] OP_SUB = 5'd2;
	localparam logic [4:0] OP_MUL = 5'd3;
	localparam logic [4:0] OP_DIV = 5'd4;
	localparam logic [4:0] OP_MOD = 5'd5;
	localparam logic [4:0] OP_SHL = 5'd6;
	localparam logic [4:0] OP_SHR = 5'd7;
	localparam logic [4:0] OP_LT  = 5'd8;
	localparam logic [4:0] OP_LE  = 5'd9;
	localparam logic [4:0] OP_GT  = 5'd10;
	localparam logic [4:0] OP_GE  = 5'd11;
	localparam logic [4:0] OP_EQ  = 5'd12;
	localparam logic [4:0] OP_NE  = 5'd13;
	localparam logic [4:0] OP_AND = 5'd14;
	localparam logic [4:0] OP_XOR = 5'd15;
	localparam logic [4:0] OP_OR  = 5'd16;

	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_POW_OVF   = 3'd1;
	localparam logic [2:0] ERR_BAD_OP    = 3'd2;
	localparam logic [2:0] ERR_BAD_WIDTH = 3'd3;
	localparam logic [2:0] ERR_DIV_ZERO  = 3'd4;

	// Width classes after decode.
	localparam logic [2:0] W_8   = 3'd0;
	localparam logic [2:0] W_16  = 3'd1;
	localparam logic [2:0] W_32  = 3'd2;
	localparam logic [2:0] W_64  = 3'd3;
	localparam logic [2:0] W_BAD = 3'd4;

	// Work classes chosen by the front end.
	localparam logic [1:0] K_DONE = 2'd0;  // result known at decode
	localparam logic [1:0] K_DIV  = 2'd1;
	localparam logic [1:0] K_MUL  = 2'd2;
	localparam logic [1:0] K_POW  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic        is_mod;
		logic        neg_q;      // negate quotient at the end
		logic        neg_r;      // negate remainder at the end
		logic        sgn;
		logic [63:0] a;          // magnitude or operand
		logic [63:0] b;
		logic [63:0] value;      // early result
		logic        is_bool;
		logic [2:0]  err;
		logic [2:0]  wcls;
	} iawc_job_t;

	typedef struct packed {
		logic [63:0] value;
		logic        is_bool;
		logic [2:0]  err;
	} iawc_res_t;

endpackage

// ===== rtl/iawc_front.sv =====
// Front end: decodes an item, finishes simple operations, prepares long ones.
module iawc_front import iawc_pkg::*; (
	input  logic [4:0]  cmd,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [6:0]  w,
	input  logic        sgn,
	output iawc_job_t   job
);
	logic [63:0] ax, bx, aneg, bneg;
	logic        lt_s, eq_v;
	logic        bigshift;

	always_comb begin
		ax = a ^ 64'h8000_0000_0000_0000;
		bx = b ^ 64'h8000_0000_0000_0000;
		aneg = ~a + 64'd1;
		bneg = ~b + 64'd1;
		lt_s = sgn ? (ax < bx) : (a < b);
		eq_v = (a == b);
		bigshift = (b[63:6] != 58'd0);
		job = '0;
		job.sgn = sgn;
		job.a = a;
		job.b = b;
		case (w)
			7'd8:    job.wcls = W_8;
			7'd16:   job.wcls = W_16;
			7'd32:   job.wcls = W_32;
			7'd64:   job.wcls = W_64;
			default: job.wcls = W_BAD;
		endcase
		case (cmd)
			OP_POW: begin
				if (b == 64'd0 || (sgn && b[63])) job.value = 64'd1;
				else if (a == 64'd0) job.value = 64'd0;
				else if (a == 64'd1) job.value = 64'd1;
				else if (sgn && a[63]) job.err = ERR_POW_OVF;
				else job.kind = K_POW;
			end
			OP_ADD: job.value = a + b;
			OP_SUB: job.value = a - b;
			OP_MUL: job.kind = K_MUL;
			OP_DIV, OP_MOD: begin
				job.is_mod = (cmd == OP_MOD);
				if (b == 64'd0) job.err = ERR_DIV_ZERO;
				else begin
					job.kind = K_DIV;
					if (sgn) begin
						job.a = a[63] ? aneg : a;
						job.b = b[63] ? bneg : b;
						job.neg_q = a[63] ^ b[63];
						job.neg_r = a[63];
					end
				end
			end
			OP_SHL: job.value = bigshift ? 64'd0 : (a << b[5:0]);
			OP_SHR: begin
				if (sgn && a[63]) job.value = bigshift ? '1 : ~((~a) >> b[5:0]);
				else job.value = bigshift ? 64'd0 : (a >> b[5:0]);
			end
			OP_LT: begin job.value = {63'd0, lt_s}; job.is_bool = 1'b1; end
			OP_LE: begin job.value = {63'd0, lt_s | eq_v}; job.is_bool = 1'b1; end
			OP_GT: begin job.value = {63'd0, ~lt_s & ~eq_v}; job.is_bool = 1'b1; end
			OP_GE: begin job.value = {63'd0, ~lt_s}; job.is_bool = 1'b1; end
			OP_EQ: begin job.value = {63'd0, eq_v}; job.is_bool = 1'b1; end
			OP_NE: begin job.value = {63'd0, ~eq_v}; job.is_bool = 1'b1; end
			OP_AND: job.value = a & b;
			OP_XOR: job.value = a ^ b;
			OP_OR:  job.value = a | b;
			default: job.err = ERR_BAD_OP;
		endcase
	end
endmodule

// ===== rtl/iawc_queue.sv =====
// Two-entry queue between the front end and the execution unit.
module iawc_queue import iawc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  iawc_job_t in_job,
	output logic      out_valid,
	input  logic      out_ready,
	output iawc_job_t out_job
);
	iawc_job_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      wr, rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job   = mem_q[rp_q];
	assign wr = in_valid & in_ready;
	assign rd = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

// ===== rtl/iawc_exec.sv =====
// Back end: iterative divider, split multiplier, stepwise power, width cast.
module iawc_exec import iawc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  iawc_job_t job,
	output logic      res_valid,
	input  logic      res_ready,
	output iawc_res_t res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_POWC = 3'd3;
	localparam logic [2:0] ST_POWM = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]  st_q;
	iawc_job_t   j_q;
	logic [63:0] quo_q, rem_q, acc_q, cnt_q, r_q;
	logic [1:0]  part_q;
	logic [6:0]  step_q;
	logic        ovf_q;
	logic [63:0] value_q;
	logic        vld_q;
	iawc_res_t   res_q;

	logic [64:0] rsh, rdiff;
	logic [31:0] ma, mb;
	logic [63:0] pp;
	logic [63:0] limit;
	logic [63:0] fin_v, cast_v;
	logic [2:0]  fin_e;
	logic [63:0] div_rem, div_quo, div_v;
	logic [63:0] pow_add, pow_sum;
	logic        pow_cy, pow_lost, pow_ovf;

	assign job_ready = (st_q == ST_IDLE);
	assign res_valid = vld_q;
	assign res = res_q;

	always_comb begin
		rsh = {rem_q, quo_q[63]};
		rdiff = rsh - {1'b0, j_q.b};
		div_rem = rdiff[64] ? rsh[63:0] : rdiff[63:0];
		div_quo = {quo_q[62:0], ~rdiff[64]};
		if (j_q.is_mod) div_v = j_q.neg_r ? ~div_rem + 64'd1 : div_rem;
		else div_v = j_q.neg_q ? ~div_quo + 64'd1 : div_quo;
		// 32x32 partial product; parts 0..2 build the low 64 bits of a*b
		case (part_q)
			2'd0: begin ma = j_q.a[31:0]; mb = j_q.b[31:0]; end
			2'd1: begin ma = j_q.a[63:32]; mb = j_q.b[31:0]; end
			default: begin ma = j_q.a[31:0]; mb = j_q.b[63:32]; end
		endcase
		pp = {32'd0, ma} * {32'd0, mb};
		limit = j_q.sgn ? 64'h7FFF_FFFF_FFFF_FFFF : '1;
		// One shift-add step of r_q times the base; bits pushed past bit 63
		// or a carry out of the sum mean the product no longer fits.
		pow_add = j_q.a[step_q[5:0]] ? (r_q << step_q[5:0]) : 64'd0;
		{pow_cy, pow_sum} = {1'b0, acc_q} + {1'b0, pow_add};
		pow_lost = j_q.a[step_q[5:0]] && step_q != 7'd0 &&
			(r_q >> (7'd64 - step_q)) != 64'd0;
		pow_ovf = pow_cy | pow_lost | (step_q == 7'd63 && pow_sum > limit);
		fin_v = value_q;
		fin_e = ovf_q ? ERR_POW_OVF : ERR_OK;
		case (j_q.wcls)
			W_8:  cast_v = {{56{fin_v[7]}}, fin_v[7:0]};
			W_16: cast_v = {{48{fin_v[15]}}, fin_v[15:0]};
			W_32: cast_v = {{32{fin_v[31]}}, fin_v[31:0]};
			default: cast_v = fin_v;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (job_valid) begin
				j_q <= job;
				quo_q <= job.a;
				rem_q <= 64'd0;
				acc_q <= 64'd0;
				part_q <= 2'd0;
				step_q <= 7'd0;
				r_q <= 64'd1;
				cnt_q <= job.b;
				ovf_q <= 1'b0;
				value_q <= job.value;
			end
			ST_DIV: begin
				rem_q <= div_rem;
				quo_q <= div_quo;
				step_q <= step_q + 7'd1;
				if (step_q == 7'd63) value_q <= div_v;
			end
			ST_MUL: begin
				case (part_q)
					2'd0: acc_q <= pp;
					default: acc_q <= acc_q + {pp[31:0], 32'd0};
				endcase
				part_q <= part_q + 2'd1;
				if (part_q == 2'd2) value_q <= acc_q + {pp[31:0], 32'd0};
			end
			ST_POWC: begin
				// Check whether the exponent is used up or the product overflowed.
				acc_q <= 64'd0;
				if (cnt_q == 64'd0 || ovf_q) value_q <= ovf_q ? 64'd0 : r_q;
			end
			ST_POWM: begin
				// multiply r_q by base using shift-add, one bit per cycle
				acc_q <= pow_sum;
				if (pow_ovf) ovf_q <= 1'b1;
				if (step_q == 7'd63) begin
					step_q <= 7'd0;
					r_q <= pow_sum;
					cnt_q <= cnt_q - 64'd1;
				end else begin
					step_q <= step_q + 7'd1;
				end
			end
			ST_FIN: if (res_ready | ~vld_q) begin
				res_q.value <= (fin_e != ERR_OK || j_q.err != ERR_OK) ? 64'd0 :
					(j_q.is_bool ? fin_v : (j_q.wcls == W_BAD ? 64'd0 : cast_v));
				res_q.is_bool <= j_q.is_bool && j_q.err == ERR_OK;
				res_q.err <= (j_q.err != ERR_OK) ? j_q.err :
					(fin_e != ERR_OK) ? fin_e :
					(!j_q.is_bool && j_q.wcls == W_BAD) ? ERR_BAD_WIDTH : ERR_OK;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			vld_q <= 1'b0;
		end else begin
			if (st_q == ST_FIN && (res_ready | ~vld_q)) vld_q <= 1'b1;
			else if (res_ready) vld_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (job_valid) begin
					case (job.kind)
						K_DIV:   st_q <= ST_DIV;
						K_MUL:   st_q <= ST_MUL;
						K_POW:   st_q <= ST_POWC;
						default: st_q <= ST_FIN;
					endcase
				end
				ST_DIV: if (step_q == 7'd63) st_q <= ST_FIN;
				ST_MUL: if (part_q == 2'd2) st_q <= ST_FIN;
				ST_POWC: st_q <= (cnt_q == 64'd0 || ovf_q) ? ST_FIN : ST_POWM;
				ST_POWM: if (step_q == 7'd63) st_q <= ST_POWC;
				ST_FIN: if (res_ready | ~vld_q) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/int_alu_width_cast_unit.sv =====
// Top level of the 64-bit integer ALU with result width cast.
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  s_axis  | in  | cmd[4:0] left_operand[68:5] right_operand[132:69] | -
//          |     | type_width[139:133] is_signed[140], pad to 144    |
//  m_axis  | out | result_value[63:0] error_code[66:64], pad to 72   | is_boolean
//
// Simple operations pass through the queue, the job register of the back end
// and its result register once the request is accepted. Divide and modulo run
// in the restoring divider, multiply on one 32x32 unit. Power repeats multiply
// steps on the shift-add unit, and the running product overflows within 64
// steps. Reset clears the queue and the control state only. Two requests fit
// in the queue, so the decoder keeps accepting until both entries are taken
// while the back end is busy or its output stalls.
module int_alu_width_cast_unit import iawc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,   // cmd, left_operand, right_operand, type_width, is_signed
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,   // result_value, error_code
	output logic         m_axis_tuser    // is_boolean
);
	iawc_job_t dec_job, q_job;
	logic      q_valid, q_ready;
	iawc_res_t res;

	iawc_front u_front (
		.cmd(s_axis_tdata[4:0]),
		.a(s_axis_tdata[68:5]),
		.b(s_axis_tdata[132:69]),
		.w(s_axis_tdata[139:133]),
		.sgn(s_axis_tdata[140]),
		.job(dec_job)
	);

	iawc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job(dec_job),
		.out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
	);

	iawc_exec u_exec (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'd0, res.err, res.value};
	assign m_axis_tuser = res.is_bool;

	// A boolean result never carries an error and is 0 or 1.
	a_bool: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[66:64] == ERR_OK &&
		m_axis_tdata[63:1] == 63'd0) else $error("bad boolean result");
	// Any error forces a zero value.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[66:64] != ERR_OK |-> m_axis_tdata[63:0] == 64'd0)
		else $error("error with nonzero value");
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the integer ALU with result width cast.
module tb;
	import iawc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [4:0]  cmd;
		logic [63:0] lhs;
		logic [63:0] rhs;
		logic [6:0]  width;
		logic        sgn;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic        is_bool;
		logic [2:0]  err;
	} alu_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;   // cmd, left_operand, right_operand, type_width, is_signed
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;   // result_value, error_code
	logic         m_axis_tuser;   // is_boolean

	alu_req_t pending_reqs[$];
	alu_res_t expected_results[$];
	int       errors = 0;
	int       sent = 0;
	int       received = 0;
	int       idle_cycles = 0;
	int       src_gap = 0;
	int       sink_gap = 0;
	int       hold_left = 0;
	bit       hold_done = 0;
	bit       stim_done = 0;
	int       op_seen[32];
	int       err_seen[8];

	int_alu_width_cast_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bit-exact prediction of one ALU request.
	function automatic alu_res_t alu_predict(alu_req_t r);
		alu_res_t    o;
		logic [63:0] a, b, v, limit, acc, lx, rx;
		logic        flag;
		logic [2:0]  e;
		logic        bl;
		v = '0;
		e = ERR_OK;
		bl = 1'b0;
		a = r.lhs;
		b = r.rhs;
		lx = a ^ 64'h8000_0000_0000_0000;
		rx = b ^ 64'h8000_0000_0000_0000;
		case (r.cmd)
		OP_POW: begin
			limit = r.sgn ? 64'h7FFF_FFFF_FFFF_FFFF : '1;
			if (b == 0 || (r.sgn && b[63])) begin
				v = 1;
			end else if (a == 0) begin
				v = 0;
			end else if (a == 1) begin
				v = 1;
			end else if (r.sgn && a[63]) begin
				e = ERR_POW_OVF;
			end else begin
				// A base of two or more overflows within 64 steps.
				acc = 1;
				flag = 1'b0;
				for (int i = 0; i < 65 && !flag && i < b; i++) begin
					if (acc > limit / a) flag = 1'b1;
					else acc = acc * a;
				end
				if (flag) e = ERR_POW_OVF;
				else v = acc;
			end
		end
		OP_ADD: v = a + b;
		OP_SUB: v = a - b;
		OP_MUL: v = a * b;
		OP_DIV, OP_MOD: begin
			if (b == 0) begin
				e = ERR_DIV_ZERO;
			end else if (!r.sgn) begin
				v = (r.cmd == OP_DIV) ? a / b : a % b;
			end else if (a == 64'h8000_0000_0000_0000 && b == '1) begin
				// The most negative value over -1 wraps around.
				v = (r.cmd == OP_DIV) ? a : 64'd0;
			end else begin
				v = (r.cmd == OP_DIV) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
			end
		end
		OP_SHL: v = (b >= 64) ? 64'd0 : a << b[5:0];
		OP_SHR: begin
			if (r.sgn && a[63]) v = (b >= 64) ? '1 : ~((~a) >> b[5:0]);
			else v = (b >= 64) ? 64'd0 : a >> b[5:0];
		end
		OP_LT: begin v = r.sgn ? (lx < rx) : (a < b); bl = 1; end
		OP_LE: begin v = r.sgn ? (lx <= rx) : (a <= b); bl = 1; end
		OP_GT: begin v = r.sgn ? (lx > rx) : (a > b); bl = 1; end
		OP_GE: begin v = r.sgn ? (lx >= rx) : (a >= b); bl = 1; end
		OP_EQ: begin v = (a == b); bl = 1; end
		OP_NE: begin v = (a != b); bl = 1; end
		OP_AND: v = a & b;
		OP_XOR: v = a ^ b;
		OP_OR: v = a | b;
		default: e = ERR_BAD_OP;
		endcase
		// Width is checked only after the operation-level errors, and not for booleans.
		if (e == ERR_OK && !bl) begin
			case (r.width)
			7'd8: v = {{56{v[7]}}, v[7:0]};
			7'd16: v = {{48{v[15]}}, v[15:0]};
			7'd32: v = {{32{v[31]}}, v[31:0]};
			7'd64: v = v;
			default: e = ERR_BAD_WIDTH;
			endcase
		end
		if (e != ERR_OK) begin
			v = '0;
			bl = 1'b0;
		end
		o.value = v;
		o.is_bool = bl;
		o.err = e;
		return o;
	endfunction

	function automatic logic [63:0] rand_operand();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 9))
		0: x = 64'h8000_0000_0000_0000;
		1: x = 64'h7FFF_FFFF_FFFF_FFFF;
		2: x = '1;
		3: x = '0;
		4: x = 64'($urandom_range(0, 70));
		5: x = -$signed(64'($urandom_range(1, 70)));
		6: x = {{32{x[31]}}, x[31:0]};
		default: ;
		endcase
		return x;
	endfunction

	function automatic logic [6:0] rand_width();
		case ($urandom_range(0, 9))
		0: return 7'($urandom_range(0, 127));
		1, 2: return 7'd8;
		3, 4: return 7'd16;
		5, 6: return 7'd32;
		default: return 7'd64;
		endcase
	endfunction

	task automatic add_req(logic [4:0] c, logic [63:0] l, logic [63:0] r,
			logic [6:0] w, logic s);
		alu_req_t q;
		q.cmd = c;
		q.lhs = l;
		q.rhs = r;
		q.width = w;
		q.sgn = s;
		pending_reqs.push_back(q);
	endtask

	// Stimulus: directed corner cases, then a random mix.
	initial begin
		logic [4:0] c;
		logic [63:0] base;
		for (int i = 0; i < 32; i++) op_seen[i] = 0;
		for (int i = 0; i < 8; i++) err_seen[i] = 0;
		add_req(OP_POW, 64'd0, 64'd0, 7'd64, 1'b0);
		add_req(OP_POW, 64'd0, 64'd5, 7'd64, 1'b0);
		add_req(OP_POW, 64'd7, '1, 7'd64, 1'b1);
		add_req(OP_POW, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 7'd8, 1'b0);
		add_req(OP_POW, '1, 64'd3, 7'd64, 1'b1);
		add_req(OP_POW, 64'd2, 64'd63, 7'd64, 1'b1);
		add_req(OP_POW, 64'd2, 64'd63, 7'd64, 1'b0);
		add_req(OP_POW, 64'd3, 64'd40, 7'd32, 1'b0);
		add_req(OP_DIV, 64'd5, 64'd0, 7'd64, 1'b1);
		add_req(OP_MOD, 64'd5, 64'd0, 7'd100, 1'b0);
		add_req(OP_DIV, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
		add_req(OP_MOD, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
		add_req(OP_DIV, -64'sd7, 64'd2, 7'd16, 1'b1);
		add_req(OP_MOD, -64'sd7, 64'd2, 7'd8, 1'b1);
		add_req(OP_SHL, '1, 64'd64, 7'd64, 1'b0);
		add_req(OP_SHR, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
		add_req(OP_SHR, 64'h8000_0000_0000_0000, 64'd63, 7'd64, 1'b0);
		add_req(OP_LT, '1, 64'd0, 7'd3, 1'b1);
		add_req(OP_GE, '1, 64'd0, 7'd0, 1'b0);
		add_req(OP_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 7'd64, 1'b1);
		add_req(5'd31, '1, '1, 7'd127, 1'b1);
		add_req(5'd17, '0, '0, 7'd64, 1'b0);
		add_req(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 7'd7, 1'b1);
		add_req(OP_OR, 64'h0000_0000_0000_0080, '0, 7'd8, 1'b0);
		for (int i = 0; i < 950; i++) begin
			c = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 16));
			if (c == OP_POW && $urandom_range(0, 1)) begin
				// Small bases and exponents let some results stay short of overflow.
				base = $urandom_range(0, 1) ? 64'($urandom_range(0, 9))
					: -$signed(64'($urandom_range(1, 9)));
				add_req(c, base, 64'($urandom_range(0, 70)), rand_width(),
					1'($urandom));
			end else begin
				add_req(c, rand_operand(), rand_operand(), rand_width(), 1'($urandom));
			end
		end
		stim_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: offers the next request after a random gap.
	always @(posedge clk or negedge arst_n) begin
		alu_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(alu_predict(pending_reqs.pop_front()));
				op_seen[s_axis_tdata[4:0]]++;
				sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0 || pending_reqs.size() == 0) begin
					s_axis_tvalid <= 1'b0;
					if (src_gap > 0) src_gap <= src_gap - 1;
				end else begin
					nxt = pending_reqs[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {3'b0, nxt.sgn, nxt.width, nxt.rhs, nxt.lhs, nxt.cmd};
					src_gap <= ($urandom_range(0, 3) != 0) ? 0
						: ($urandom_range(0, 9) == 0 ? $urandom_range(10, 200)
							: $urandom_range(1, 4));
				end
			end
		end
	end

	// Monitor: random back-pressure and one long hold-off on the output.
	always @(posedge clk or negedge arst_n) begin
		alu_res_t got, exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap <= 0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata[63:0];
				got.err = m_axis_tdata[66:64];
				got.is_bool = m_axis_tuser;
				received++;
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected: value=%h err=%0d bool=%b",
						$time, got.value, got.err, got.is_bool);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					err_seen[got.err]++;
					if (got.value !== exp_r.value) begin
						$display("%0t: result_value expected %h actual %h",
							$time, exp_r.value, got.value);
						errors++;
					end
					if (got.err !== exp_r.err) begin
						$display("%0t: error_code expected %0d actual %0d",
							$time, exp_r.err, got.err);
						errors++;
					end
					if (got.is_bool !== exp_r.is_bool) begin
						$display("%0t: is_boolean expected %b actual %b",
							$time, exp_r.is_bool, got.is_bool);
						errors++;
					end
				end
			end
			if (!hold_done && sent >= 100) begin
				// Long stall so the input queue fills and tready drops.
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					sink_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 150)
						: $urandom_range(1, 4);
			end
		end
	end

	// Watchdog: counts cycles in which neither side moves a request.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout with %0d results outstanding", expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int ops;
		wait (stim_done);
		wait (pending_reqs.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		ops = 0;
		for (int i = 0; i < 32; i++) if (op_seen[i] > 0) ops++;
		$display("Covered %0d requests over %0d distinct opcodes, %0d results checked.",
			sent, ops, received);
		$display("Error codes seen: ok=%0d ovf=%0d op=%0d width=%0d div0=%0d",
			err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4]);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
